// ===== hw/rtl/skf_pkg.sv =====
// ----------------------------------------------------------------------------
// skf_pkg: shared types and constants for the scalar kalman filter
// fixed-point widths, register map codes, reset values and serial step counts
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int Q_W    = 32;
    localparam int K_W    = 17;
    localparam int ADDR_W = 4;
    localparam int CNT_W  = 5;

    typedef logic [Q_W-1:0]    t_word;
    typedef logic [K_W-1:0]    t_gain;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

    localparam t_gain K_ONE     = 17'h1_0000;
    localparam t_cnt  LAST_STEP = CNT_W'(K_W - 1);

    localparam logic [1:0] REG_PROCESS_NOISE     = 2'd0;
    localparam logic [1:0] REG_MEASUREMENT_NOISE = 2'd1;
    localparam logic [1:0] REG_DRIFT_PER_STEP    = 2'd2;

    localparam t_word RST_PROCESS_NOISE     = 32'd655;
    localparam t_word RST_MEASUREMENT_NOISE = 32'd65536;
    localparam t_word RST_DRIFT_PER_STEP    = 32'd0;

endpackage

// ===== hw/rtl/skf_div.sv =====
// ----------------------------------------------------------------------------
// skf_div: serial restoring divider for the gain
// one quotient bit per cycle, gives floor(num * 2^16 / den) for num <= den
// ----------------------------------------------------------------------------
module skf_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  skf_pkg::t_word    i_num,
    input  logic [skf_pkg::Q_W:0] i_den,
    output logic              o_done,
    output skf_pkg::t_gain    o_quot
);
    import skf_pkg::*;

    logic             r_busy;
    logic             r_done;
    t_cnt             r_cnt;
    logic [Q_W+1:0]   r_rem;
    logic [Q_W:0]     r_den;
    t_gain            r_quot;

    logic             ge;
    logic [Q_W+1:0]   rem_sub;

    always_comb begin
        ge      = (r_rem >= {1'b0, r_den});
        rem_sub = ge ? (r_rem - {1'b0, r_den}) : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {2'b00, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= {rem_sub[Q_W:0], 1'b0};
            r_quot <= {r_quot[K_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== hw/rtl/skf_mul.sv =====
// ----------------------------------------------------------------------------
// skf_mul: serial shift-add multiplier with a 2^-16 scale
// multiplier bits taken lsb first, gives floor(a * m / 2^16) for 17-bit m
// ----------------------------------------------------------------------------
module skf_mul #(
    parameter int A_W = 33
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [A_W-1:0] i_a,
    input  skf_pkg::t_gain        i_m,
    output logic                  o_done,
    output logic signed [A_W:0]   o_prod
);
    import skf_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    t_cnt                  r_cnt;
    logic signed [A_W-1:0] r_a;
    t_gain                 r_m;
    logic signed [A_W:0]   r_acc;

    logic signed [A_W:0]   addend;
    logic signed [A_W:0]   sum;

    always_comb begin
        addend = r_m[0] ? (A_W+1)'(r_a) : '0;
        sum    = r_acc + addend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // floor of each halving composes into floor of the whole scaled product
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_m   <= i_m;
            r_acc <= '0;
        end else if (r_busy) begin
            r_m <= r_m >> 1;
            if (r_cnt == LAST_STEP) begin
                r_acc <= sum;
            end else begin
                r_acc <= sum >>> 1;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== hw/rtl/scalar_kalman_filter.sv =====
// ----------------------------------------------------------------------------
// scalar_kalman_filter: one-dimensional kalman filter in fixed point
// predict, serial gain division, serial correction of estimate and covariance
// a taken sample passes the predict, divide, multiply and finish states in turn;
// no new sample is taken until it is through; the divide state runs the 17-step serial divider,
// the multiply state the two 17-step serial multipliers working side by side
// a result may wait in the output register while the next sample is taken
// reset: synchronous active low, clears state to zero and registers to defaults
// ----------------------------------------------------------------------------
module scalar_kalman_filter #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  skf_pkg::t_addr                 paddr,
    input  skf_pkg::t_word                 pwdata,
    output skf_pkg::t_word                 prdata,
    output logic                           pready,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_estimate,
    output skf_pkg::t_gain                 o_gain
);
    import skf_pkg::*;

    localparam int MW = (SAMPLE_WIDTH + 8 > Q_W) ? SAMPLE_WIDTH + 8 : Q_W;
    localparam int DW = MW + 1;
    localparam int PW = DW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRED = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    localparam logic signed [PW:0] XMAX = (PW+1)'(64'sh7FFF_FFFF);
    localparam logic signed [PW:0] XMIN = (PW+1)'(-64'sh8000_0000);
    localparam logic signed [32:0] SMAX = (33'sd1 <<< (SAMPLE_WIDTH - 1)) - 33'sd1;
    localparam logic signed [32:0] SMIN = -(33'sd1 <<< (SAMPLE_WIDTH - 1));

    logic [2:0]                    r_state;
    t_word                         r_q;
    t_word                         r_r;
    t_word                         r_u;
    logic signed [Q_W-1:0]         r_x_last;
    t_word                         r_p_last;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic signed [Q_W-1:0]         r_x_mid;
    t_word                         r_p_mid;
    t_gain                         r_k;
    logic                          r_div_start;
    logic                          r_mul_start;
    logic                          r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_est;
    t_gain                         r_gain;

    logic                          cfg_wr;
    logic                          in_take;
    logic                          out_free;
    logic signed [Q_W:0]           x_pred_sum;
    logic signed [Q_W-1:0]         x_pred;
    logic [Q_W:0]                  p_pred_sum;
    t_word                         p_pred;
    logic [Q_W:0]                  div_den;
    logic signed [DW-1:0]          meas;
    logic signed [DW-1:0]          diff;
    t_gain                         m_cov;
    logic                          div_done;
    t_gain                         div_quot;
    logic                          corr_done;
    logic signed [PW-1:0]          corr;
    logic                          cov_done;
    logic signed [Q_W+1:0]         p_prod;
    logic signed [PW:0]            x_sum;
    logic signed [Q_W-1:0]         x_now;
    logic signed [32:0]            est_full;
    logic signed [32:0]            est_sat;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb begin
        unique case (paddr[3:2])
            REG_PROCESS_NOISE:     prdata = r_q;
            REG_MEASUREMENT_NOISE: prdata = r_r;
            REG_DRIFT_PER_STEP:    prdata = r_u;
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= RST_PROCESS_NOISE;
            r_r <= RST_MEASUREMENT_NOISE;
            r_u <= RST_DRIFT_PER_STEP;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_PROCESS_NOISE:     r_q <= pwdata;
                REG_MEASUREMENT_NOISE: r_r <= pwdata;
                REG_DRIFT_PER_STEP:    r_u <= pwdata;
                default: ;
            endcase
        end
    end

    // prediction
    always_comb begin
        x_pred_sum = {r_x_last[Q_W-1], r_x_last} + $signed({r_u[Q_W-1], r_u});
        if (x_pred_sum[Q_W] != x_pred_sum[Q_W-1]) begin
            x_pred = x_pred_sum[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
        end else begin
            x_pred = x_pred_sum[Q_W-1:0];
        end
        p_pred_sum = {1'b0, r_p_last} + {1'b0, r_q};
        p_pred     = p_pred_sum[Q_W] ? '1 : p_pred_sum[Q_W-1:0];
    end

    // gain and correction operands
    always_comb begin
        div_den = {1'b0, r_p_mid} + {1'b0, r_r};
        meas    = DW'(r_sample) <<< 8;
        diff    = meas - DW'(r_x_mid);
        m_cov   = K_ONE - r_k;
    end

    skf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_p_mid),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    skf_mul #(.A_W(DW)) u_mul_corr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (diff),
        .i_m     (r_k),
        .o_done  (corr_done),
        .o_prod  (corr)
    );

    skf_mul #(.A_W(Q_W + 1)) u_mul_cov (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     ($signed({1'b0, r_p_mid})),
        .i_m     (m_cov),
        .o_done  (cov_done),
        .o_prod  (p_prod)
    );

    // correction and output scaling
    always_comb begin
        x_sum = (PW+1)'(r_x_mid) + (PW+1)'(corr);
        if (x_sum > XMAX) begin
            x_now = {1'b0, {(Q_W-1){1'b1}}};
        end else if (x_sum < XMIN) begin
            x_now = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            x_now = x_sum[Q_W-1:0];
        end
        est_full = 33'(r_x_last) >>> 8;
        if (est_full > SMAX) begin
            est_sat = SMAX;
        end else if (est_full < SMIN) begin
            est_sat = SMIN;
        end else begin
            est_sat = est_full;
        end
    end

    assign in_take  = i_in_valid & (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_mul_start <= 1'b0;
            r_out_valid <= 1'b0;
            r_x_last    <= '0;
            r_p_last    <= '0;
        end else begin
            r_div_start <= 1'b0;
            r_mul_start <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_state <= S_PRED;
                    end
                end
                S_PRED: begin
                    r_div_start <= 1'b1;
                    r_state     <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_mul_start <= 1'b1;
                        r_state     <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (corr_done && cov_done) begin
                        r_x_last <= x_now;
                        r_p_last <= p_prod[Q_W-1:0];
                        r_state  <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_sample <= i_sample;
        end
        if (r_state == S_PRED) begin
            r_x_mid <= x_pred;
            r_p_mid <= p_pred;
        end
        // zero denominator gives zero gain
        if (r_state == S_DIV && div_done) begin
            r_k <= (div_den == '0) ? '0 : div_quot;
        end
        if (r_state == S_FIN && out_free) begin
            r_est  <= est_sat[SAMPLE_WIDTH-1:0];
            r_gain <= r_k;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_estimate  = r_est;
    assign o_gain      = r_gain;

endmodule

// ===== hw/rtl/skf_checker.sv =====
// ----------------------------------------------------------------------------
// skf_checker: port-level checks for the scalar kalman filter
// busy window after a transaction, gain range, held results, apb ready
// ----------------------------------------------------------------------------
module skf_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input skf_pkg::t_addr                 paddr,
    input skf_pkg::t_word                 pwdata,
    input skf_pkg::t_word                 prdata,
    input logic                           pready,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic signed [SAMPLE_WIDTH-1:0] o_estimate,
    input skf_pkg::t_gain                 o_gain
);
    import skf_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid & !o_in_stall;

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input taken again right after a transaction");

    a_busy_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ##20 o_in_stall)
        else $error("input free again before the serial steps can finish");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_gain <= K_ONE))
        else $error("gain above unity");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_estimate) && $stable(o_gain)))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable) |-> pready)
        else $error("apb access not ready");

endmodule

bind scalar_kalman_filter skf_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_skf_checker (.*);

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the scalar kalman filter
// a queue-fed driver offers sensor samples and a fixed-point copy of the filter
// predicts estimate and gain at each accepted transaction; a monitor compares
// every result in order. directed steps cover the zero denominator, saturation
// of drift and estimate, unity gain and an unmapped register write; random
// steps follow under three sender and receiver idling mixes and one long hold
// ----------------------------------------------------------------------------
module tb_top;
    import skf_pkg::*;

    localparam int SW            = 16;
    localparam int SETTLE_CYCLES = 60;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int BATCH_ITEMS   = 72;
    localparam int HOLD_AT       = 150;
    localparam int HOLD_CYCLES   = 300;

    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint EST_MAX = (64'sd1 <<< (SW - 1)) - 1;
    localparam longint EST_MIN = -(64'sd1 <<< (SW - 1));

    typedef logic signed [SW-1:0] t_sample;

    typedef struct {
        t_sample estimate;
        t_gain   gain;
    } t_kalman_out;

    logic    i_clk      = 1'b0;
    logic    i_rst_n    = 1'b0;
    logic    psel       = 1'b0;
    logic    penable    = 1'b0;
    logic    pwrite     = 1'b0;
    t_addr   paddr      = '0;
    t_word   pwdata     = '0;
    t_word   prdata;
    logic    pready;
    logic    in_valid   = 1'b0;
    logic    in_stall;
    t_sample in_sample  = '0;
    logic    out_valid;
    logic    out_stall  = 1'b0;
    t_sample out_estimate;
    t_gain   out_gain;

    // filter state and registers as the predictor sees them
    logic signed [31:0] x_state = '0;
    t_word              cov_state = '0;
    t_word              q_reg = RST_PROCESS_NOISE;
    t_word              r_reg = RST_MEASUREMENT_NOISE;
    t_word              u_reg = RST_DRIFT_PER_STEP;

    t_sample     pending_samples[$];
    t_kalman_out expected_outputs[$];

    int tx_idle_pct = 35;
    int rx_idle_pct = 46;
    int mismatch_count = 0;
    int results_seen = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int cycle_count = 0;

    scalar_kalman_filter #(
        .SAMPLE_WIDTH(SW)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_sample   (in_sample),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_estimate (out_estimate),
        .o_gain     (out_gain)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic longint sat32(input longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    // one predict and correct step, updating the filter state
    function automatic t_kalman_out kalman_step(input t_sample smp);
        longint          meas, x_mid, corr, x_now, est;
        longint unsigned p_mid, den, k, p_now;
        t_kalman_out     res;
        meas  = longint'(smp) * 256;
        x_mid = sat32(longint'(x_state) + longint'($signed(u_reg)));
        p_mid = longint'({32'd0, cov_state}) + longint'({32'd0, q_reg});
        if (p_mid > 64'hFFFF_FFFF) p_mid = 64'hFFFF_FFFF;
        den = p_mid + longint'({32'd0, r_reg});
        if (den == 0) k = 0;
        else k = (p_mid << 16) / den;
        corr  = (longint'(k) * (meas - x_mid)) >>> 16;
        x_now = sat32(x_mid + corr);
        p_now = ((64'd65536 - k) * p_mid) >> 16;
        x_state   = x_now[31:0];
        cov_state = p_now[31:0];
        est = x_now >>> 8;
        if (est > EST_MAX) est = EST_MAX;
        if (est < EST_MIN) est = EST_MIN;
        res.estimate = est[SW-1:0];
        res.gain     = k[K_W-1:0];
        return res;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) expected_outputs.push_back(kalman_step(in_sample));
            if (!in_valid || !in_stall) begin
                if (pending_samples.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    in_sample <= pending_samples.pop_front();
                    in_valid  <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_kalman_out exp_out;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (expected_outputs.size() == 0) begin
                    $error("unexpected transaction: estimate %0d gain %0d",
                           out_estimate, out_gain);
                    mismatch_count++;
                end else begin
                    exp_out = expected_outputs.pop_front();
                    if (out_estimate !== exp_out.estimate) begin
                        $error("estimate mismatch: expected %0d, actual %0d",
                               exp_out.estimate, out_estimate);
                        mismatch_count++;
                    end
                    if (out_gain !== exp_out.gain) begin
                        $error("gain mismatch: expected %0d, actual %0d",
                               exp_out.gain, out_gain);
                        mismatch_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input t_word value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= t_addr'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PROCESS_NOISE:     q_reg = value;
            REG_MEASUREMENT_NOISE: r_reg = value;
            REG_DRIFT_PER_STEP:    u_reg = value;
            default: ;
        endcase
    endtask

    task automatic configure(input t_word q, input t_word r, input t_word u);
        cfg_write(REG_PROCESS_NOISE, q);
        cfg_write(REG_MEASUREMENT_NOISE, r);
        cfg_write(REG_DRIFT_PER_STEP, u);
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (pending_samples.size() != 0 || in_valid || expected_outputs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_word extreme_word();
        case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic t_sample random_sample();
        case ($urandom_range(0, 9))
            0:       return t_sample'(EST_MAX);
            1:       return t_sample'(EST_MIN);
            2:       return t_sample'($urandom_range(0, 1) ? 0 : -1);
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic random_config(input int style);
        case (style)
            0: configure($urandom_range(0, 32'h0002_0000), $urandom_range(0, 32'h0004_0000),
                         t_word'(int'($urandom_range(0, 8191)) - 4096));
            1: configure($urandom, $urandom, $urandom);
            default: configure(extreme_word(), extreme_word(), extreme_word());
        endcase
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero denominator from the cleared covariance
        configure(32'd0, 32'd0, 32'd0);
        pending_samples = '{16'sh7FFF, -16'sh8000, 16'sh0000};
        drain();

        // zero gain, drift pushes the estimate to both rails
        configure(32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        repeat (4) pending_samples.push_back(random_sample());
        drain();
        cfg_write(REG_DRIFT_PER_STEP, 32'h8000_0000);
        repeat (3) pending_samples.push_back(random_sample());
        drain();

        // full-scale covariance, unity gain follows the sample
        configure(32'hFFFF_FFFF, 32'd0, 32'd0);
        pending_samples = '{16'sh7FFF, -16'sh8000, -16'sh0001, 16'sh0001, 16'sh0000};
        drain();

        // defaults, plus a write to an unmapped register
        configure(RST_PROCESS_NOISE, RST_MEASUREMENT_NOISE, RST_DRIFT_PER_STEP);
        cfg_write(REG_UNMAPPED, $urandom);
        pending_samples = '{16'sh5555, -16'sh5556, 16'sh0100, -16'sh0100, 16'sh0064};
        drain();

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    tx_idle_pct = 35;
                    rx_idle_pct = 46;
                end
                1: begin
                    tx_idle_pct = 46;
                    rx_idle_pct = 35;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int style = 0; style < 3; style++) begin
                random_config(style);
                repeat (BATCH_ITEMS) pending_samples.push_back(random_sample());
                drain();
            end
        end

        if (mismatch_count == 0 && expected_outputs.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== scalar_kalman_filter.f =====
hw/rtl/skf_pkg.sv
hw/rtl/skf_div.sv
hw/rtl/skf_mul.sv
hw/rtl/scalar_kalman_filter.sv
hw/rtl/skf_checker.sv
test/tb_top.sv
